>>> design/ffba_pkg.sv
`timescale 1ns / 1ps
// Shared codes for the first-fit block allocator: actions and result status.
// No dependencies.
package ffba_pkg;

    localparam int ActionW = 2;
    localparam int StatusW = 3;

    localparam logic [ActionW-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ActionW-1:0] ACT_FREE  = 2'd1;
    localparam logic [ActionW-1:0] ACT_INIT  = 2'd2;
    localparam logic [ActionW-1:0] ACT_NOP   = 2'd3;

    localparam logic [StatusW-1:0] ST_OK      = 3'd0;
    localparam logic [StatusW-1:0] ST_ZERO    = 3'd1;
    localparam logic [StatusW-1:0] ST_NOSPACE = 3'd2;
    localparam logic [StatusW-1:0] ST_NULL    = 3'd3;
    localparam logic [StatusW-1:0] ST_OOB     = 3'd4;
    localparam logic [StatusW-1:0] ST_DOUBLE  = 3'd5;

endpackage

>>> design/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// First-fit block allocator: address-ordered free list with coalescing.
// Segment table {len,next} and allocation lengths live in two RAMs with registered reads.
// Alloc walks the free list until a segment fits and splits off the rest at its tail;
// free walks to the insert point and merges with adjacent free segments; init clears
// the length RAM one entry per cycle. One request at a time.
// Reset runs the same clearing pass with heap_blocks 1024, no beat out.
module first_fit_block_allocator #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [10:0]                     i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ffba_pkg::ActionW-1:0]    i_action,
    input  logic [10:0]                     i_size_blocks,
    input  logic [11:0]                     i_handle,
    input  logic                            i_handle_null,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ffba_pkg::StatusW-1:0]    o_status,
    output logic [9:0]                      o_block_index
);
    import ffba_pkg::*;

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int LW = $clog2(NUM_BLOCKS + 1);
    localparam int HW = (LW > 12) ? LW : 12;
    localparam int XW = HW + 1;
    localparam logic [LW-1:0] END_MARK = LW'(NUM_BLOCKS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BLOCKS - 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_A_RD, S_A_CHK, S_A_WR,
        S_F_AL, S_F_RD, S_F_CHK, S_F_DEC, S_F_WR, S_DONE
    } t_state;

    // segment RAM, {len, next}
    logic [2*LW-1:0] seg_mem [NUM_BLOCKS];
    logic [2*LW-1:0] r_seg_rd;
    logic            seg_we;
    logic [AW-1:0]   seg_waddr, seg_raddr;
    logic [2*LW-1:0] seg_wdata;

    logic [LW-1:0]   alen_mem [NUM_BLOCKS];
    logic [LW-1:0]   r_alen_rd;
    logic            alen_we;
    logic [AW-1:0]   alen_waddr, alen_raddr;
    logic [LW-1:0]   alen_wdata;

    always_ff @(posedge i_clk) begin
        if (seg_we) seg_mem[seg_waddr] <= seg_wdata;
        r_seg_rd <= seg_mem[seg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (alen_we) alen_mem[alen_waddr] <= alen_wdata;
        r_alen_rd <= alen_mem[alen_raddr];
    end

    t_state            r_state, n_state;
    logic [10:0]       r_heap_blocks;
    logic [LW-1:0]     r_heap_size, n_heap_size;
    logic [LW-1:0]     r_head, n_head;
    logic [LW-1:0]     r_cur, n_cur, r_prev, n_prev, r_prev_len, n_prev_len;
    logic [LW-1:0]     r_cur_len, n_cur_len, r_cur_next, n_cur_next;
    logic [LW-1:0]     r_len, n_len, r_h, n_h, r_tgt, n_tgt;
    logic [10:0]       r_size, n_size;
    logic [StatusW-1:0] r_st, n_st, n_status;
    logic [9:0]        r_idx, n_idx, n_bidx;
    logic              r_init_resp, n_init_resp, n_out_valid;
    logic [AW-1:0]     r_clr, n_clr;

    logic [LW-1:0]     rd_len, rd_next;
    logic [XW-1:0]     prev_end, h_end, tail;
    logic [LW-1:0]     len_h, next_h, hb_min;
    logic              merge_r, merge_l;

    assign rd_len  = r_seg_rd[2*LW-1:LW];
    assign rd_next = (r_seg_rd[LW-1:0] >= END_MARK) ? END_MARK : r_seg_rd[LW-1:0];
    assign prev_end = XW'(r_prev) + XW'(r_prev_len);
    assign h_end    = XW'(r_h) + XW'(r_len);
    assign tail     = XW'(r_cur) + XW'(r_size);
    assign merge_r  = (r_cur != END_MARK) && (h_end == XW'(r_cur));
    assign merge_l  = (r_prev != END_MARK) && (prev_end == XW'(r_h));
    assign len_h    = merge_r ? LW'(r_len + r_cur_len) : r_len;
    assign next_h   = merge_r ? r_cur_next : r_cur;
    assign hb_min   = (XW'(r_heap_blocks) > XW'(NUM_BLOCKS)) ? END_MARK : LW'(r_heap_blocks);

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;     n_heap_size = r_heap_size; n_head = r_head;
        n_cur = r_cur;         n_prev = r_prev;           n_prev_len = r_prev_len;
        n_cur_len = r_cur_len; n_cur_next = r_cur_next;   n_len = r_len;
        n_h = r_h;             n_tgt = r_tgt;             n_size = r_size;
        n_st = r_st;           n_idx = r_idx;             n_init_resp = r_init_resp;
        n_clr = r_clr;
        n_out_valid = o_out_valid & ~i_out_ready;
        n_status = o_status;   n_bidx = o_block_index;
        seg_we = 1'b0;  seg_waddr = '0; seg_wdata = '0; seg_raddr = r_cur[AW-1:0];
        alen_we = 1'b0; alen_waddr = '0; alen_wdata = '0; alen_raddr = AW'(i_handle);

        unique case (r_state)
            S_CLR: begin
                alen_we = 1'b1; alen_waddr = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_clr = '0;
                    n_heap_size = hb_min;
                    if (hb_min == '0) begin
                        n_head = END_MARK;
                    end else begin
                        n_head = '0;
                        seg_we = 1'b1; seg_waddr = '0; seg_wdata = {hb_min, END_MARK};
                    end
                    n_st = ST_OK; n_idx = '0;
                    n_state = r_init_resp ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_st = ST_OK; n_idx = '0; n_state = S_DONE;
                    n_size = i_size_blocks;
                    n_cur = r_head; n_prev = END_MARK;
                    n_h = LW'(i_handle);
                    case (i_action)
                        ACT_ALLOC: begin
                            if (i_size_blocks == '0) n_st = ST_ZERO;
                            else n_state = S_A_RD;
                        end
                        ACT_FREE: begin
                            if (i_handle_null) n_st = ST_NULL;
                            else if (HW'(i_handle) >= HW'(r_heap_size)) n_st = ST_OOB;
                            else n_state = S_F_AL;
                        end
                        ACT_INIT: begin
                            n_init_resp = 1'b1; n_clr = '0; n_state = S_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            S_A_RD: begin
                if (r_cur == END_MARK) begin
                    n_st = ST_NOSPACE; n_state = S_DONE;
                end else begin
                    n_state = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (XW'(rd_len) >= XW'(r_size)) begin
                    n_tgt = rd_next;
                    if ((XW'(rd_len) != XW'(r_size)) && (tail < XW'(NUM_BLOCKS))) begin
                        seg_we = 1'b1; seg_waddr = tail[AW-1:0];
                        seg_wdata = {LW'(XW'(rd_len) - XW'(r_size)), rd_next};
                        n_tgt = LW'(tail);
                    end
                    n_state = S_A_WR;
                end else begin
                    n_prev = r_cur; n_prev_len = rd_len; n_cur = rd_next;
                    n_state = S_A_RD;
                end
            end
            S_A_WR: begin
                if (r_prev == END_MARK) n_head = r_tgt;
                else begin
                    seg_we = 1'b1; seg_waddr = r_prev[AW-1:0]; seg_wdata = {r_prev_len, r_tgt};
                end
                alen_we = 1'b1; alen_waddr = r_cur[AW-1:0]; alen_wdata = LW'(r_size);
                n_st = ST_OK; n_idx = 10'(r_cur); n_state = S_DONE;
            end
            S_F_AL: begin
                n_len = r_alen_rd;
                if (r_alen_rd == '0) begin
                    n_st = ST_DOUBLE; n_state = S_DONE;
                end else begin
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                n_state = (r_cur == END_MARK) ? S_F_DEC : S_F_CHK;
            end
            S_F_CHK: begin
                if (r_cur > r_h) begin
                    n_cur_len = rd_len; n_cur_next = rd_next; n_state = S_F_DEC;
                end else begin
                    n_prev = r_cur; n_prev_len = rd_len; n_cur = rd_next;
                    n_state = S_F_RD;
                end
            end
            S_F_DEC: begin
                n_state = S_DONE;
                if ((r_prev != END_MARK) && (XW'(r_h) < prev_end)) n_st = ST_DOUBLE;
                else if ((r_cur != END_MARK) && (h_end > XW'(r_cur))) n_st = ST_DOUBLE;
                else begin
                    n_st = ST_OK;
                    alen_we = 1'b1; alen_waddr = r_h[AW-1:0];
                    seg_we = 1'b1;
                    if (merge_l) begin
                        // h folds into the left neighbor; its own entry is never listed
                        seg_waddr = r_prev[AW-1:0];
                        seg_wdata = {LW'(r_prev_len + len_h), next_h};
                    end else begin
                        seg_waddr = r_h[AW-1:0];
                        seg_wdata = {len_h, next_h};
                        n_state = S_F_WR;
                    end
                end
            end
            S_F_WR: begin
                if (r_prev == END_MARK) n_head = r_h;
                else begin
                    seg_we = 1'b1; seg_waddr = r_prev[AW-1:0]; seg_wdata = {r_prev_len, r_h};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!o_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1; n_status = r_st; n_bidx = r_idx;
                    n_init_resp = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_clr         <= '0;
            r_init_resp   <= 1'b0;
            r_heap_blocks <= 11'd1024;
            o_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_init_resp <= n_init_resp;
            o_out_valid <= n_out_valid;
            if (i_cfg_we) r_heap_blocks <= i_cfg_wdata;
        end
        r_heap_size <= n_heap_size; r_head <= n_head;
        r_cur <= n_cur;         r_prev <= n_prev;       r_prev_len <= n_prev_len;
        r_cur_len <= n_cur_len; r_cur_next <= n_cur_next;
        r_len <= n_len;         r_h <= n_h;             r_tgt <= n_tgt;
        r_size <= n_size;       r_st <= n_st;           r_idx <= n_idx;
        o_status <= n_status;   o_block_index <= n_bidx;
    end

endmodule
